// ----- rtl/ecc_image_sector_mapper_unit_assert.svh -----
// Assertion macros for the sector mapper checker.
// Each macro expects clk and arst_n in the calling scope.
`ifndef ECC_IMAGE_SECTOR_MAPPER_UNIT_ASSERT_SVH
`define ECC_IMAGE_SECTOR_MAPPER_UNIT_ASSERT_SVH

// same-cycle implication
`define EISM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("eism check failed");

// next-cycle implication
`define EISM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("eism check failed");

`endif

// ----- rtl/eism_pkg.sv -----
`default_nettype none
package eism_pkg;

	localparam int SECTOR_BITS = 33;
	localparam int HM_BITS     = 31;
	localparam int SLICE_BITS  = 8;
	localparam int CFG_BITS    = (SECTOR_BITS > HM_BITS) ? SECTOR_BITS : HM_BITS;
	localparam int FR_BITS     = CFG_BITS + 1;
	// forward product / ecc offset width
	localparam int EXT_BITS    = SECTOR_BITS + SLICE_BITS;
	localparam int CNT_BITS    = $clog2(SECTOR_BITS);
	// accept edge to result edge
	localparam int LATENCY     = EXT_BITS + SECTOR_BITS + 7;

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_DATA    = 2'd0;
	localparam kind_t KIND_ECC     = 2'd1;
	localparam kind_t KIND_HEADER  = 2'd2;
	localparam kind_t KIND_INVALID = 2'd3;

	localparam int CFG_IDX_BITS = 2;
	typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_PROT  = 2'd0;
	localparam cfg_idx_t CFG_LAYER = 2'd1;
	localparam cfg_idx_t CFG_DATA  = 2'd2;
	localparam cfg_idx_t CFG_HMOD  = 2'd3;

	localparam logic            OP_FORWARD = 1'b0;
	localparam logic            OP_INVERSE = 1'b1;

	localparam logic [SECTOR_BITS-1:0] RST_PROT  = SECTOR_BITS'(3);
	localparam logic [SECTOR_BITS-1:0] RST_LAYER = SECTOR_BITS'(1);
	localparam logic [SLICE_BITS-1:0]  RST_DATA  = SLICE_BITS'(255);
	localparam logic [HM_BITS-1:0]     RST_HMOD  = HM_BITS'(32);
	localparam logic [HM_BITS-1:0]     MIN_HMOD  = HM_BITS'(32);
	localparam logic [FR_BITS-1:0]     RST_FR    = FR_BITS'(32);
	localparam logic [HM_BITS-1:0]     RST_BASE  = HM_BITS'(29);

	typedef struct packed {
		logic                   operation;
		logic [SLICE_BITS-1:0]  slice_in;
		logic [SECTOR_BITS-1:0] index_in;
		logic [SECTOR_BITS-1:0] sector_in;
	} request_t;

	typedef struct packed {
		kind_t                  kind;
		logic [SECTOR_BITS-1:0] sector_out;
		logic [SLICE_BITS-1:0]  slice_out;
		logic [SECTOR_BITS-1:0] index_out;
	} result_t;

	// effective configuration plus derived layout values
	typedef struct packed {
		logic [SECTOR_BITS-1:0] prot;
		logic [SECTOR_BITS-1:0] spl;
		logic [SLICE_BITS-1:0]  ds;
		logic [HM_BITS-1:0]     hm;
		logic [FR_BITS-1:0]     fr;
		logic [HM_BITS-1:0]     base;
	} cfg_t;

endpackage
`default_nettype wire

// ----- rtl/ecc_image_sector_mapper_unit.sv -----
`default_nettype none
// Channel   Handshake              Payload
// request   start / busy           request (operation, slice_in, index_in, sector_in)
// result    done (strobe only)     result (kind, sector_out, slice_out, index_out)
// config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One transaction per cycle while busy is low; each result comes out in request
// order through the two bit-per-stage dividers (41 + 33 stages).
// After a config write busy stays high while the bit-serial unit rebuilds the
// first header repeat; cfg_ready is low during that time.
// Reset clears all valid bits and restores the config reset values.
// The receiver cannot stall, so the pipeline never holds.
module ecc_image_sector_mapper_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire eism_pkg::request_t            request,
	output logic                               done,
	output eism_pkg::result_t                  result,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire eism_pkg::cfg_idx_t            cfg_index,
	input  wire logic [eism_pkg::CFG_BITS-1:0] cfg_data
);
	import eism_pkg::*;

	localparam int SB  = SECTOR_BITS;
	localparam int EW  = EXT_BITS;
	localparam int SW  = EW + 1;
	localparam int SLW = SB + 1;

	// carried through the first divider
	typedef struct packed {
		logic          op;
		logic          fdata;
		logic [EW-1:0] e;
		logic          lt_base;
		logic          lt_ps;
		logic          lt_fr;
		logic [SB-1:0] sector;
	} side1_t;

	// carried through the second divider
	typedef struct packed {
		logic          op;
		kind_t         fkind;
		logic [SB-1:0] fsec;
		logic          hdr;
		logic [SB-1:0] hidx;
		logic          lt_ps;
	} side2_t;

	cfg_t cfg;
	logic accept;

	eism_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.busy      (busy)
	);

	assign accept = start && !busy;

	// ---------------- stage 1: capture request ----------------
	logic     v_s1;
	request_t req_s1;

	// ---------------- stage 2: multiply, sector compares ----------------
	logic                  fdata_c;
	logic [SLICE_BITS-1:0] m_c;
	logic [EW-1:0]         prod_c;
	logic                  v_s2, op_s2, fdata_s2, lt_ps_s2, lt_fr_s2;
	logic [EW-1:0]         prod_s2;
	logic [SB-1:0]         n_s2, sector_s2, d_s2;
	logic [FR_BITS-1:0]    d_wide_c;

	// ---------------- stage 3: layer offset ----------------
	logic                  v_s3, op_s3, fdata_s3, lt_ps_s3, lt_fr_s3;
	logic [EW-1:0]         e_s3;
	logic [SB-1:0]         sector_s3, d_s3;

	// ---------------- first divider: by header modulo ----------------
	side1_t                side1_in, side1_out;
	logic                  lt_base_c;
	logic [EW-1:0]         num1_c;
	logic [HM_BITS-1:0]    den1_c;
	logic                  v1_out;
	logic [EW-1:0]         q1;
	logic [HM_BITS-1:0]    r1;

	// ---------------- stage 4: resolve forward, prepare inverse ----------------
	logic [SW-1:0]         fadj_c, fs_c;
	kind_t                 fkind_c;
	logic [SB-1:0]         fsec_c;
	logic [SLW-1:0]        iadj_c, t_c;
	side2_t                side2_c;
	logic                  v_s4;
	side2_t                side2_s4;
	logic [SB-1:0]         num2_s4;

	// ---------------- second divider: by layer size ----------------
	logic                  v2_out;
	logic [SB-1:0]         q2, r2;
	side2_t                side2_out;

	// ---------------- stage 5: output ----------------
	logic [SLW-1:0]        sl_c;
	result_t               res_c;
	logic                  done_s5;
	result_t               res_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			done_s5 <= 1'b0;
		end else begin
			v_s1    <= accept;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v1_out;
			done_s5 <= v2_out;
		end
	end

	always_ff @(posedge clk) begin
		req_s1 <= request;
	end

	// data slices map from their own number, ecc slices from the offset past the data
	assign fdata_c  = req_s1.slice_in < cfg.ds;
	assign m_c      = fdata_c ? req_s1.slice_in : req_s1.slice_in - cfg.ds;
	assign prod_c   = m_c * cfg.spl;
	assign d_wide_c = FR_BITS'(req_s1.sector_in) - cfg.fr;

	always_ff @(posedge clk) begin
		op_s2     <= req_s1.operation;
		fdata_s2  <= fdata_c;
		prod_s2   <= prod_c;
		n_s2      <= req_s1.index_in;
		sector_s2 <= req_s1.sector_in;
		lt_ps_s2  <= req_s1.sector_in < cfg.prot;
		lt_fr_s2  <= FR_BITS'(req_s1.sector_in) < cfg.fr;
		d_s2      <= d_wide_c[SB-1:0];
	end

	always_ff @(posedge clk) begin
		op_s3     <= op_s2;
		fdata_s3  <= fdata_s2;
		e_s3      <= prod_s2 + EW'(n_s2);
		sector_s3 <= sector_s2;
		lt_ps_s3  <= lt_ps_s2;
		lt_fr_s3  <= lt_fr_s2;
		d_s3      <= d_s2;
	end

	// forward: ecc offset past the first repeat over (modulo - 2) data sectors
	// inverse: distance past the first repeat over the modulo
	assign lt_base_c = e_s3 < EW'(cfg.base);
	assign num1_c    = (op_s3 == OP_INVERSE) ? EW'(d_s3) : e_s3 - EW'(cfg.base);
	assign den1_c    = (op_s3 == OP_INVERSE) ? cfg.hm : cfg.hm - HM_BITS'(2);

	always_comb begin
		side1_in.op      = op_s3;
		side1_in.fdata   = fdata_s3;
		side1_in.e       = e_s3;
		side1_in.lt_base = lt_base_c;
		side1_in.lt_ps   = lt_ps_s3;
		side1_in.lt_fr   = lt_fr_s3;
		side1_in.sector  = sector_s3;
	end

	eism_div #(
		.NW (EW),
		.DW (HM_BITS),
		.PW ($bits(side1_t))
	) u_div_hm (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (v_s3),
		.in_num   (num1_c),
		.in_den   (den1_c),
		.in_side  (side1_in),
		.out_vld  (v1_out),
		.out_quo  (q1),
		.out_rem  (r1),
		.out_side (side1_out)
	);

	// forward ecc sector = protected + offset, plus two per header copy passed
	assign fadj_c = side1_out.lt_base ? '0 : SW'(2) + {q1, 1'b0};
	assign fs_c   = SW'(cfg.prot) + SW'(side1_out.e) + fadj_c;

	always_comb begin
		if (side1_out.fdata) begin
			if (side1_out.e < EW'(cfg.prot)) begin
				fkind_c = KIND_DATA;
				fsec_c  = side1_out.e[SB-1:0];
			end else begin
				fkind_c = KIND_INVALID;
				fsec_c  = '0;
			end
		end else if (fs_c[SW-1:SB] != '0) begin
			fkind_c = KIND_INVALID;
			fsec_c  = '0;
		end else begin
			fkind_c = KIND_ECC;
			fsec_c  = fs_c[SB-1:0];
		end
	end

	// inverse ecc offset: drop protected area and all header copies so far
	assign iadj_c = side1_out.lt_fr ? '0 : SLW'(2) + {q1[SB-1:0], 1'b0};
	assign t_c    = SLW'(side1_out.sector) - SLW'(cfg.prot) - iadj_c;

	always_comb begin
		side2_c.op    = side1_out.op;
		side2_c.fkind = fkind_c;
		side2_c.fsec  = fsec_c;
		side2_c.hdr   = !side1_out.lt_ps && !side1_out.lt_fr && (r1 < HM_BITS'(2));
		side2_c.hidx  = q1[SB-1:0];
		side2_c.lt_ps = side1_out.lt_ps;
	end

	always_ff @(posedge clk) begin
		side2_s4 <= side2_c;
		num2_s4  <= side1_out.lt_ps ? side1_out.sector : t_c[SB-1:0];
	end

	eism_div #(
		.NW (SB),
		.DW (SB),
		.PW ($bits(side2_t))
	) u_div_spl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (v_s4),
		.in_num   (num2_s4),
		.in_den   (cfg.spl),
		.in_side  (side2_s4),
		.out_vld  (v2_out),
		.out_quo  (q2),
		.out_rem  (r2),
		.out_side (side2_out)
	);

	assign sl_c = (side2_out.lt_ps ? '0 : SLW'(cfg.ds)) + SLW'(q2);

	always_comb begin
		res_c = '0;
		if (side2_out.op == OP_FORWARD) begin
			res_c.kind       = side2_out.fkind;
			res_c.sector_out = side2_out.fsec;
		end else if (side2_out.hdr) begin
			res_c.kind      = KIND_HEADER;
			res_c.index_out = side2_out.hidx;
		end else if (sl_c > SLW'(8'hFF)) begin
			res_c.kind = KIND_INVALID;
		end else begin
			res_c.kind      = side2_out.lt_ps ? KIND_DATA : KIND_ECC;
			res_c.slice_out = sl_c[SLICE_BITS-1:0];
			res_c.index_out = r2;
		end
	end

	always_ff @(posedge clk) begin
		res_s5 <= res_c;
	end

	assign done   = done_s5;
	assign result = res_s5;

endmodule
`default_nettype wire

// ----- rtl/eism_div.sv -----
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage.
module eism_div #(
	parameter int NW = 8,
	parameter int DW = 8,
	parameter int PW = 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_vld,
	input  wire logic [NW-1:0] in_num,
	input  wire logic [DW-1:0] in_den,
	input  wire logic [PW-1:0] in_side,
	output logic               out_vld,
	output logic [NW-1:0]      out_quo,
	output logic [DW-1:0]      out_rem,
	output logic [PW-1:0]      out_side
);

	logic [NW:0]   vld_s;
	logic [DW-1:0] rem_s  [NW+1];
	logic [NW-1:0] nq_s   [NW+1];
	logic [DW-1:0] den_s  [NW+1];
	logic [PW-1:0] side_s [NW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[NW-1:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0]  <= '0;
		nq_s[0]   <= in_num;
		den_s[0]  <= in_den;
		side_s[0] <= in_side;
	end

	for (genvar k = 0; k < NW; k++) begin : g_step
		logic [DW:0] trial;
		logic [DW:0] diff;
		logic        ge;
		assign trial = {rem_s[k], nq_s[k][NW-1]};
		assign diff  = trial - {1'b0, den_s[k]};
		assign ge    = trial >= {1'b0, den_s[k]};
		always_ff @(posedge clk) begin
			rem_s[k+1]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
			nq_s[k+1]   <= {nq_s[k][NW-2:0], ge};
			den_s[k+1]  <= den_s[k];
			side_s[k+1] <= side_s[k];
		end
	end

	assign out_vld  = vld_s[NW];
	assign out_quo  = nq_s[NW];
	assign out_rem  = rem_s[NW];
	assign out_side = side_s[NW];

endmodule
`default_nettype wire

// ----- rtl/eism_cfg.sv -----
`default_nettype none
// Config registers; after each write, derives the first header repeat
// (protected rounded up to a multiple of the modulo) bit-serially.
module eism_cfg (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire eism_pkg::cfg_idx_t         cfg_index,
	input  wire logic [eism_pkg::CFG_BITS-1:0] cfg_data,
	output eism_pkg::cfg_t                  cfg,
	output logic                            busy
);
	import eism_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CALC = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]             state_q;
	logic [CNT_BITS-1:0]    cnt_q;
	logic [HM_BITS-1:0]     rem_q;
	logic [SECTOR_BITS-1:0] prot_q;
	logic [SECTOR_BITS-1:0] spl_q;
	logic [SLICE_BITS-1:0]  ds_q;
	logic [HM_BITS-1:0]     hm_q;
	logic [FR_BITS-1:0]     fr_q;
	logic [HM_BITS-1:0]     base_q;

	logic [HM_BITS-1:0]     hm_eff;
	logic [HM_BITS:0]       trial;
	logic [HM_BITS:0]       diff;
	logic                   ge;
	logic [HM_BITS-1:0]     adj;
	logic                   wr;

	assign hm_eff = (hm_q < MIN_HMOD) ? MIN_HMOD : hm_q;
	assign trial  = {rem_q, prot_q[cnt_q]};
	assign diff   = trial - {1'b0, hm_eff};
	assign ge     = trial >= {1'b0, hm_eff};
	assign adj    = (rem_q == '0) ? '0 : hm_eff - rem_q;
	assign busy   = state_q != ST_IDLE;
	assign cfg_ready = !busy;
	assign wr     = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			rem_q   <= '0;
			prot_q  <= RST_PROT;
			spl_q   <= RST_LAYER;
			ds_q    <= RST_DATA;
			hm_q    <= RST_HMOD;
			fr_q    <= RST_FR;
			base_q  <= RST_BASE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (wr) begin
						unique case (cfg_index)
							CFG_PROT:  prot_q <= cfg_data[SECTOR_BITS-1:0];
							CFG_LAYER: spl_q  <= cfg_data[SECTOR_BITS-1:0];
							CFG_DATA:  ds_q   <= cfg_data[SLICE_BITS-1:0];
							CFG_HMOD:  hm_q   <= cfg_data[HM_BITS-1:0];
							default: ;
						endcase
						state_q <= ST_CALC;
						cnt_q   <= CNT_BITS'(SECTOR_BITS - 1);
						rem_q   <= '0;
					end
				end
				ST_CALC: begin
					rem_q <= ge ? diff[HM_BITS-1:0] : trial[HM_BITS-1:0];
					if (cnt_q == '0) begin
						state_q <= ST_FIN;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_FIN: begin
					fr_q    <= FR_BITS'(prot_q) + FR_BITS'(adj);
					base_q  <= adj;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cfg.prot = prot_q;
		cfg.spl  = (spl_q == '0) ? SECTOR_BITS'(1) : spl_q;
		cfg.ds   = ds_q;
		cfg.hm   = hm_eff;
		cfg.fr   = fr_q;
		cfg.base = base_q;
	end

endmodule
`default_nettype wire

// ----- rtl/eism_chk.sv -----
`default_nettype none
`include "ecc_image_sector_mapper_unit_assert.svh"
module eism_chk (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          start,
	input wire logic                          busy,
	input wire eism_pkg::request_t            request,
	input wire logic                          done,
	input wire eism_pkg::result_t             result,
	input wire logic                          cfg_valid,
	input wire logic                          cfg_ready,
	input wire eism_pkg::cfg_idx_t            cfg_index,
	input wire logic [eism_pkg::CFG_BITS-1:0] cfg_data
);
	import eism_pkg::*;

	localparam int RW = $clog2(LATENCY + 1);

	// cycles since reset, so the latency check never looks back across a reset
	logic [RW-1:0] since_rst_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			since_rst_q <= '0;
		end else if (since_rst_q != RW'(LATENCY)) begin
			since_rst_q <= since_rst_q + 1'b1;
		end
	end

	`EISM_ASSERT_IMP(a_latency, since_rst_q == RW'(LATENCY), done == $past(start && !busy, LATENCY))
	`EISM_ASSERT_NXT(a_cfg_busy, cfg_valid && cfg_ready, busy && !cfg_ready)
	`EISM_ASSERT_IMP(a_invalid_zero, done && result.kind == KIND_INVALID, result.sector_out == '0 && result.slice_out == '0 && result.index_out == '0)
	`EISM_ASSERT_IMP(a_header_zero, done && result.kind == KIND_HEADER, result.sector_out == '0 && result.slice_out == '0)

endmodule

bind ecc_image_sector_mapper_unit eism_chk u_eism_chk (.*);
`default_nettype wire
